// ----- rtl/fwts_pkg.sv -----
// Package for the fixed-weight ternary sampler.
// Holds field widths, register indexes, reset values and the controller types.
// No dependencies; used by fwts_ctrl, fwts_dp and fixed_weight_ternary_sampler.
package fwts_pkg;

    // Field widths
    localparam int unsigned SEQ_LEN_W  = 11;
    localparam int unsigned WEIGHT_W   = 10;
    localparam int unsigned NEG_CODE_W = 8;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned COEFF_W    = 8;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_CODE   = 2'd2;

    localparam logic [SEQ_LEN_W-1:0]  SEQ_LENGTH_RST = 11'd512;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RST     = 10'd128;
    localparam logic [NEG_CODE_W-1:0] NEG_CODE_RST   = 8'd255;

    localparam logic [COEFF_W-1:0] COEFF_PLUS_ONE = 8'd1;

    // Run epoch stored beside each table entry; code zero means never touched
    localparam int unsigned EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 8'd0;

    // Width of the divider iteration counter
    localparam int unsigned DIV_CNT_W = 4;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_SWEEP_RUN,
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J
    } state_t;

    typedef struct packed {
        logic sweep;      // write the never-touched mark into one entry
        logic load;       // capture the random word
        logic clear_run;  // drop a stale run before the new step
        logic emit_err;   // issue an error result
        logic div_init;   // load the divisor
        logic div_step;   // one restoring division step
        logic rd_i;       // read entry i
        logic rd_j;       // read entry j, hold entry i
        logic wr_i;       // write entry i with entry j
        logic finish;     // write entry j, issue the result, advance the step
    } cmd_t;

    typedef struct packed {
        logic cfg_bad;
        logic stale;
        logic epoch_full;
        logic div_last;
        logic sweep_last;
        logic run_last;
    } status_t;

endpackage

// ----- rtl/fwts_ctrl.sv -----
// Controller state machine of the fixed-weight ternary sampler.
// Sequences table sweeps, the modulo divider and the two-entry swap.
// Depends on fwts_pkg.
module fwts_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fwts_pkg::status_t status,
    output fwts_pkg::cmd_t   cmd,
    output logic             busy
);

    fwts_pkg::state_t state_reg;
    fwts_pkg::state_t state_next;

    // State register; reset enters the table sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwts_pkg::ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            fwts_pkg::ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = fwts_pkg::ST_IDLE;
                end
            end
            fwts_pkg::ST_SWEEP_RUN:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = fwts_pkg::ST_DIV_INIT;
                end
            end
            fwts_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (status.cfg_bad)
                    begin
                        cmd.emit_err = 1'b1;
                    end
                    else
                    begin
                        cmd.load      = 1'b1;
                        cmd.clear_run = status.stale;
                        if (status.stale && status.epoch_full)
                        begin
                            state_next = fwts_pkg::ST_SWEEP_RUN;
                        end
                        else
                        begin
                            state_next = fwts_pkg::ST_DIV_INIT;
                        end
                    end
                end
            end
            fwts_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = fwts_pkg::ST_DIV;
            end
            fwts_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = fwts_pkg::ST_RD_I;
                end
            end
            fwts_pkg::ST_RD_I:
            begin
                cmd.rd_i   = 1'b1;
                state_next = fwts_pkg::ST_RD_J;
            end
            fwts_pkg::ST_RD_J:
            begin
                cmd.rd_j   = 1'b1;
                state_next = fwts_pkg::ST_WR_I;
            end
            fwts_pkg::ST_WR_I:
            begin
                cmd.wr_i   = 1'b1;
                state_next = fwts_pkg::ST_WR_J;
            end
            fwts_pkg::ST_WR_J:
            begin
                cmd.finish = 1'b1;
                if (status.run_last && status.epoch_full)
                begin
                    state_next = fwts_pkg::ST_SWEEP;
                end
                else
                begin
                    state_next = fwts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwts_pkg::ST_SWEEP;
            end
        endcase
    end

endmodule

// ----- rtl/fwts_dp.sv -----
// Datapath of the fixed-weight ternary sampler: configuration registers,
// step and epoch counters, restoring modulo divider, position memory, results.
// Depends on fwts_pkg; driven by fwts_ctrl.
module fwts_dp #(
    parameter int unsigned LEN_MAX = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fwts_pkg::cmd_t                      cmd,
    output fwts_pkg::status_t                   status,
    input  logic [fwts_pkg::WORD_W-1:0]         random_word,
    input  logic                                cfg_we,
    input  logic [fwts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fwts_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                done,
    output logic [fwts_pkg::POS_W-1:0]          position,
    output logic [fwts_pkg::COEFF_W-1:0]        coeff_value,
    output logic                                last,
    output logic                                error
);

    localparam int unsigned IW = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
    localparam int unsigned LW = $clog2(LEN_MAX + 1);
    localparam int unsigned CW = (LW > fwts_pkg::SEQ_LEN_W) ? LW : fwts_pkg::SEQ_LEN_W;
    localparam int unsigned MW = fwts_pkg::EPOCH_W + IW;

    // Configuration
    logic [fwts_pkg::SEQ_LEN_W-1:0]  seq_length_reg;
    logic [fwts_pkg::WEIGHT_W-1:0]   weight_reg;
    logic [fwts_pkg::NEG_CODE_W-1:0] neg_code_reg;

    // Run control
    logic [IW-1:0]                step_reg;
    logic [fwts_pkg::EPOCH_W-1:0] epoch_reg;
    logic [fwts_pkg::EPOCH_W-1:0] epoch_adv;
    logic [IW-1:0]                sweep_addr_reg;

    // Divider
    logic [fwts_pkg::WORD_W-1:0]    word_reg;
    logic [CW-1:0]                  div_reg;
    logic [CW-1:0]                  rem_reg;
    logic [CW-1:0]                  rem_next;
    logic [CW:0]                    trial;
    logic [fwts_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // Swap
    logic [IW-1:0] j_idx;
    logic [IW-1:0] a_reg;
    logic [IW-1:0] b_reg;
    logic [IW-1:0] entry_val;
    logic          entry_hit;

    // Memory
    logic [MW-1:0] pos_mem [LEN_MAX];
    logic [MW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;

    // Results
    logic                         done_reg;
    logic [fwts_pkg::POS_W-1:0]   position_reg;
    logic [fwts_pkg::COEFF_W-1:0] coeff_reg;
    logic                         last_reg;
    logic                         error_reg;

    // Wide views for comparisons
    logic [CW-1:0] seq_w;
    logic [CW-1:0] steps_w;
    logic [CW-1:0] step_w;
    logic [CW-1:0] weight_w;

    assign seq_w    = CW'(seq_length_reg);
    assign steps_w  = CW'({weight_reg, 1'b0});
    assign step_w   = CW'(step_reg);
    assign weight_w = CW'(weight_reg);

    // Status towards the controller
    assign status.cfg_bad    = (seq_length_reg == '0) || (seq_w > CW'(LEN_MAX))
                               || (weight_reg == '0) || (steps_w > seq_w);
    assign status.stale      = (step_w >= steps_w);
    assign status.epoch_full = (epoch_reg == '1);
    assign status.div_last   = (div_cnt_reg == fwts_pkg::DIV_CNT_W'(fwts_pkg::WORD_W - 1));
    assign status.sweep_last = (sweep_addr_reg == IW'(LEN_MAX - 1));
    assign status.run_last   = ((step_w + CW'(1)) == steps_w);

    assign epoch_adv = status.epoch_full ? fwts_pkg::EPOCH_FIRST
                                         : (epoch_reg + fwts_pkg::EPOCH_W'(1));

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg <= fwts_pkg::SEQ_LENGTH_RST;
            weight_reg     <= fwts_pkg::WEIGHT_RST;
            neg_code_reg   <= fwts_pkg::NEG_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fwts_pkg::REG_SEQ_LENGTH: seq_length_reg <= cfg_data;
                fwts_pkg::REG_WEIGHT:     weight_reg     <= cfg_data[fwts_pkg::WEIGHT_W-1:0];
                fwts_pkg::REG_NEG_CODE:   neg_code_reg   <= cfg_data[fwts_pkg::NEG_CODE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Step count and run epoch; a new epoch stands for cleared marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            epoch_reg <= fwts_pkg::EPOCH_FIRST;
        end
        else if (cmd.clear_run)
        begin
            step_reg  <= '0;
            epoch_reg <= epoch_adv;
        end
        else if (cmd.finish)
        begin
            if (status.run_last)
            begin
                step_reg  <= '0;
                epoch_reg <= epoch_adv;
            end
            else
            begin
                step_reg <= step_reg + IW'(1);
            end
        end
    end

    // Sweep address; wrap to zero after the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            if (status.sweep_last)
            begin
                sweep_addr_reg <= '0;
            end
            else
            begin
                sweep_addr_reg <= sweep_addr_reg + IW'(1);
            end
        end
    end

    // Restoring division step, one word bit per cycle, high bit first
    assign trial    = {rem_reg, word_reg[fwts_pkg::WORD_W-1]};
    assign rem_next = (trial >= {1'b0, div_reg}) ? CW'(trial - {1'b0, div_reg})
                                                 : trial[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + fwts_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= random_word;
        end
        else if (cmd.div_step)
        begin
            word_reg <= {word_reg[fwts_pkg::WORD_W-2:0], 1'b0};
        end
        if (cmd.div_init)
        begin
            div_reg <= seq_w - step_w;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end
    end

    // Swap partner: remainder stays below length minus step
    assign j_idx = step_reg + rem_reg[IW-1:0];

    // Entry read back: untouched in this run reads as its own index
    assign entry_hit = (rd_data_reg[MW-1:IW] == epoch_reg);
    assign entry_val = entry_hit ? rd_data_reg[IW-1:0] : (cmd.rd_j ? step_reg : j_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_j)
        begin
            a_reg <= entry_val;
        end
        if (cmd.wr_i)
        begin
            b_reg <= entry_val;
        end
    end

    // Memory port selection
    assign mem_re = cmd.rd_i || cmd.rd_j;
    assign mem_ra = cmd.rd_j ? j_idx : step_reg;
    assign mem_we = cmd.sweep || cmd.wr_i || cmd.finish;

    always_comb
    begin
        mem_wa = sweep_addr_reg;
        mem_wd = {fwts_pkg::EPOCH_NONE, IW'(0)};
        if (cmd.wr_i)
        begin
            mem_wa = step_reg;
            mem_wd = {epoch_reg, entry_val};
        end
        else if (cmd.finish)
        begin
            mem_wa = j_idx;
            mem_wd = {epoch_reg, a_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= pos_mem[mem_ra];
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_err || cmd.finish;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_err)
        begin
            position_reg <= '0;
            coeff_reg    <= '0;
            last_reg     <= 1'b0;
            error_reg    <= 1'b1;
        end
        else if (cmd.finish)
        begin
            position_reg <= fwts_pkg::POS_W'(b_reg);
            coeff_reg    <= (step_w < weight_w) ? fwts_pkg::COEFF_PLUS_ONE : neg_code_reg;
            last_reg     <= status.run_last;
            error_reg    <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign position    = position_reg;
    assign coeff_value = coeff_reg;
    assign last        = last_reg;
    assign error       = error_reg;

endmodule

// ----- rtl/fixed_weight_ternary_sampler.sv -----
// Fixed-weight ternary sampler: partial Fisher-Yates shuffle, one step per word.
// An accepted valid word loads the divisor, runs the bit-serial modulo, then swaps two
// table entries (read i, read j, write i, write j) and registers its result strobe.
// No new word is taken while busy; a bad setting answers with an error result from idle.
// Reset (asynchronous, rst_n low) and every 255th run end or dropped run start a
// table sweep over all LEN_MAX entries with busy high. Results cannot be stalled.
module fixed_weight_ternary_sampler #(
    parameter int unsigned LEN_MAX = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fwts_pkg::WORD_W-1:0]     random_word,
    input  logic                            cfg_we,
    input  logic [fwts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fwts_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic [fwts_pkg::POS_W-1:0]      position,
    output logic [fwts_pkg::COEFF_W-1:0]    coeff_value,
    output logic                            last,
    output logic                            error
);

    fwts_pkg::cmd_t    cmd;
    fwts_pkg::status_t status;

    // Controller
    fwts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath
    fwts_dp #(
        .LEN_MAX (LEN_MAX)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .random_word (random_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .position    (position),
        .coeff_value (coeff_value),
        .last        (last),
        .error       (error)
    );

endmodule

// ----- sim/tb_fixed_weight_ternary_sampler.sv -----
// Testbench for fixed_weight_ternary_sampler: drives random words and register settings,
// predicts each drawn position and coefficient, and checks every result strobe.
// Depends on fwts_pkg and the fixed_weight_ternary_sampler RTL.
module tb_fixed_weight_ternary_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int          ITEM_TARGET = 1850;
    localparam int          STALL_LIMIT = 5000;

    typedef struct packed {
        logic [fwts_pkg::POS_W-1:0]   pos;
        logic [fwts_pkg::COEFF_W-1:0] coeff;
        logic                         last;
        logic                         err;
    } draw_t;

    // Shuffle predictor and the queue of draws still owed by the block
    class ternary_draw_scoreboard;
        logic [fwts_pkg::POS_W-1:0]      slot_value [TABLE_DEPTH];
        bit                              slot_touched [TABLE_DEPTH];
        int unsigned                     step_idx;
        logic [fwts_pkg::SEQ_LEN_W-1:0]  seq_length;
        logic [fwts_pkg::WEIGHT_W-1:0]   weight;
        logic [fwts_pkg::NEG_CODE_W-1:0] neg_code;
        draw_t                           expected_draws[$];
        int                              fail_count;

        function void drop_run();
            foreach (slot_touched[k])
                slot_touched[k] = 1'b0;
            step_idx = 0;
        endfunction

        function void reset_state();
            drop_run();
            seq_length = fwts_pkg::SEQ_LENGTH_RST;
            weight     = fwts_pkg::WEIGHT_RST;
            neg_code   = fwts_pkg::NEG_CODE_RST;
            fail_count = 0;
        endfunction

        // Untouched slots read as their own index
        function int unsigned read_slot(int unsigned idx);
            return slot_touched[idx] ? int'(slot_value[idx]) : idx;
        endfunction

        function void write_slot(int unsigned idx, int unsigned val);
            slot_value[idx]   = val[fwts_pkg::POS_W-1:0];
            slot_touched[idx] = 1'b1;
        endfunction

        function void write_register(logic [fwts_pkg::CFG_IDX_W-1:0] idx,
                                     logic [fwts_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fwts_pkg::REG_SEQ_LENGTH: seq_length = data[fwts_pkg::SEQ_LEN_W-1:0];
                fwts_pkg::REG_WEIGHT:     weight     = data[fwts_pkg::WEIGHT_W-1:0];
                fwts_pkg::REG_NEG_CODE:   neg_code   = data[fwts_pkg::NEG_CODE_W-1:0];
                default:                  ;
            endcase
        endfunction

        // Advance the shuffle by one step for an accepted word, or owe an error beat for a bad setting
        function void note_word(logic [fwts_pkg::WORD_W-1:0] word);
            int unsigned len;
            int unsigned steps;
            int unsigned i;
            int unsigned j;
            int unsigned a;
            int unsigned b;
            draw_t       d;
            len   = seq_length;
            steps = 2 * weight;
            if (len == 0 || len > TABLE_DEPTH || weight == 0 || steps > len)
            begin
                d = '{pos: '0, coeff: '0, last: 1'b0, err: 1'b1};
            end
            else
            begin
                if (step_idx >= steps)
                    drop_run();
                i = step_idx;
                j = i + (int'(word) % (len - i));
                a = read_slot(i);
                b = read_slot(j);
                write_slot(i, b);
                write_slot(j, a);
                d.pos   = b[fwts_pkg::POS_W-1:0];
                d.coeff = (i < weight) ? fwts_pkg::COEFF_PLUS_ONE : neg_code;
                d.err   = 1'b0;
                d.last  = (i + 1 == steps);
                if (d.last)
                    drop_run();
                else
                    step_idx = i + 1;
            end
            expected_draws.push_back(d);
        endfunction

        function void check_draw(logic [fwts_pkg::POS_W-1:0] pos,
                                 logic [fwts_pkg::COEFF_W-1:0] coeff,
                                 logic last, logic err);
            draw_t d;
            if (expected_draws.size() == 0)
            begin
                $error("result beat with no draw pending: position %0d coeff %0d", pos, coeff);
                fail_count++;
                return;
            end
            d = expected_draws.pop_front();
            if (pos !== d.pos)
            begin
                $error("position: expected %0d, actual %0d", d.pos, pos);
                fail_count++;
            end
            if (coeff !== d.coeff)
            begin
                $error("coeff_value: expected %0d, actual %0d", d.coeff, coeff);
                fail_count++;
            end
            if (last !== d.last)
            begin
                $error("last: expected %0d, actual %0d", d.last, last);
                fail_count++;
            end
            if (err !== d.err)
            begin
                $error("error: expected %0d, actual %0d", d.err, err);
                fail_count++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [fwts_pkg::WORD_W-1:0]     random_word;
    logic                            cfg_we;
    logic [fwts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fwts_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            done;
    logic [fwts_pkg::POS_W-1:0]      position;
    logic [fwts_pkg::COEFF_W-1:0]    coeff_value;
    logic                            last;
    logic                            error;

    ternary_draw_scoreboard sb;
    int                     words_sent;
    int                     stall_cycles;

    fixed_weight_ternary_sampler #(
        .LEN_MAX(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .random_word(random_word),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .position(position),
        .coeff_value(coeff_value),
        .last(last),
        .error(error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Observe register writes, accepted words and result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_register(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_word(random_word);
            if (done)
                sb.check_draw(position, coeff_value, last, error);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("fixed_weight_ternary_sampler test failed");
            $finish;
        end
    end

    function automatic logic [fwts_pkg::WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return fwts_pkg::WORD_W'($urandom_range(0, 65535));
    endfunction

    // Present one word and hold it until the block takes it
    task automatic send_word(input logic [fwts_pkg::WORD_W-1:0] word);
        random_word <= word;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    // Send random words in bursts, with gaps unless steady
    task automatic send_words(input int count, input bit steady);
        int burst;
        int k;
        burst = $urandom_range(1, 16);
        for (k = 0; k < count; k++)
        begin
            send_word(pick_word());
            burst--;
            if (!steady && burst == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30))
                    @(posedge clk);
                burst = $urandom_range(1, 16);
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                // hold off until every pending draw has come back
                start <= 1'b0;
                do
                    @(posedge clk);
                while (sb.expected_draws.size() != 0);
            end
        end
    endtask

    // Drop start and wait for the block to drain and go idle
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_draws.size() != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [fwts_pkg::CFG_IDX_W-1:0] idx, input int data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= fwts_pkg::CFG_DATA_W'(data);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input int len, input int wt, input int neg);
        write_reg(fwts_pkg::REG_SEQ_LENGTH, len);
        write_reg(fwts_pkg::REG_WEIGHT, wt);
        write_reg(fwts_pkg::REG_NEG_CODE, neg);
    endtask

    initial
    begin
        int r;
        int len;
        int wt;
        int steps;
        int rem;
        int count;
        clk_init_inputs:
        begin
            rst_n       = 1'b0;
            start       = 1'b0;
            random_word = '0;
            cfg_we      = 1'b0;
            cfg_index   = '0;
            cfg_data    = '0;
            words_sent  = 0;
        end
        sb = new();
        sb.reset_state();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, extreme words
        settle();
        send_word('0);
        send_word('1);

        // Largest table and weight, negative code zero; the partial run carries on
        settle();
        set_config(1024, 512, 0);
        send_word('1);
        send_word(16'h0001);

        // Invalid settings: each answers with an error beat
        settle();
        write_reg(fwts_pkg::REG_SEQ_LENGTH, 0);
        send_word(16'h1234);
        settle();
        write_reg(fwts_pkg::REG_SEQ_LENGTH, 2047);
        send_word(16'hABCD);
        settle();
        write_reg(fwts_pkg::REG_SEQ_LENGTH, 1025);
        send_word(16'h5555);
        settle();
        set_config(1024, 0, 255);
        send_word(16'hAAAA);
        settle();
        set_config(10, 6, 255);
        send_word(16'h00FF);
        settle();
        set_config(1024, 1023, 255);
        send_word(16'hFF00);

        // Out-of-range index is ignored; shortest run drops the stale one
        settle();
        write_reg(2'd3, 2047);
        set_config(2, 1, 8'h80);
        send_word('1);
        send_word('0);
        send_word(16'h7FFF);
        send_word(16'h8000);

        // Mid-run change keeps the partial table
        settle();
        set_config(8, 4, 255);
        send_word(pick_word());
        send_word(pick_word());
        send_word(pick_word());
        settle();
        write_reg(fwts_pkg::REG_SEQ_LENGTH, 16);
        write_reg(fwts_pkg::REG_NEG_CODE, 8'hAA);
        repeat (5)
            send_word(pick_word());

        // Random phases of settings and word streams
        while (words_sent < ITEM_TARGET)
        begin
            settle();
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        len = 0;
                        wt  = $urandom_range(1, 512);
                    end
                    1:
                    begin
                        len = $urandom_range(1025, 2047);
                        wt  = $urandom_range(1, 512);
                    end
                    2:
                    begin
                        len = $urandom_range(2, 1024);
                        wt  = 0;
                    end
                    default:
                    begin
                        len = $urandom_range(1, 200);
                        wt  = $urandom_range(len / 2 + 1, 1023);
                    end
                endcase
                count = $urandom_range(1, 3);
            end
            else
            begin
                if (r == 1)
                begin
                    len = $urandom_range(513, 1024);
                    wt  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len / 2)
                                                      : $urandom_range(1, 8);
                end
                else
                begin
                    len = $urandom_range(2, 64);
                    wt  = $urandom_range(1, len / 2);
                end
                steps = 2 * wt;
                rem   = (sb.step_idx < steps) ? steps - int'(sb.step_idx) : steps;
                if ($urandom_range(0, 3) != 0)
                    count = rem + steps * $urandom_range(0, 3);
                else
                    count = $urandom_range(1, steps);
                if (count > 300)
                    count = 300;
            end
            // Stop close to the item target
            if (count > ITEM_TARGET - words_sent)
                count = ITEM_TARGET - words_sent;
            write_reg(fwts_pkg::REG_SEQ_LENGTH, len);
            write_reg(fwts_pkg::REG_WEIGHT, wt);
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(fwts_pkg::REG_NEG_CODE, 0);
                    1:       write_reg(fwts_pkg::REG_NEG_CODE, 255);
                    default: write_reg(fwts_pkg::REG_NEG_CODE, $urandom_range(0, 255));
                endcase
            end
            send_words(count, $urandom_range(0, 3) == 0);
        end

        // Drain, then allow a margin for stray beats
        settle();
        repeat (50)
            @(posedge clk);
        if (sb.fail_count == 0)
            $display("fixed_weight_ternary_sampler test passed");
        else
            $display("fixed_weight_ternary_sampler test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fwts_pkg.sv
rtl/fwts_ctrl.sv
rtl/fwts_dp.sv
rtl/fixed_weight_ternary_sampler.sv
sim/tb_fixed_weight_ternary_sampler.sv
